### sv/amgc_pkg.sv
// amgc_pkg: shared types and codes of the adjacency matrix graph checker
// used by amgc_ctrl, amgc_dpath and adjacency_matrix_graph_checker; no dependencies

package amgc_pkg;

   localparam int MAX_VERTICES_DEFAULT = 16;

   localparam int VERTEX_W = 5;
   localparam int ACTION_W = 2;
   localparam int COUNT_W  = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [ACTION_W-1:0] ACT_CONNECT    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DISCONNECT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_INQUIRE    = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNKNOWN    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDIRECTED   = 1'd1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [VERTEX_W-1:0] source;
      logic [VERTEX_W-1:0] dest;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               edge_present;
      logic [COUNT_W-1:0] row_count;
      logic [COUNT_W-1:0] column_count;
      logic               all_reachable;
      logic               eulerian;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EW_WR_SRC,
      ST_EW_RD_DST,
      ST_EW_WR_DST,
      ST_SCAN,
      ST_WALK_PICK,
      ST_WALK_ACC,
      ST_RESPOND
   } ctrl_state_type;

   typedef enum logic [1:0] {
      ADDR_SRC,
      ADDR_DST,
      ADDR_SCAN,
      ADDR_PICK
   } addr_sel_type;

   typedef struct packed {
      logic         load;
      addr_sel_type addr_sel;
      logic         wr_src;
      logic         wr_dst;
      logic         scan_issue;
      logic         walk_pick;
      logic         walk_acc;
      logic         respond;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                ok;
      logic                undirected;
      logic                n_zero;
      logic                scan_last;
      logic                pending_any;
   } status_type;

endpackage

### sv/adjacency_matrix_graph_checker.sv
// Adjacency matrix graph checker. A command is taken when start is high and busy is low;
// its single result shows on rsp_item for exactly one cycle with rsp_valid high and cannot
// be held off, so the receiver must take it then. A connect or disconnect passes through
// decode, the source row write and respond (undirected mode also reads and writes the
// mirrored row); a refused edge write or an unknown action goes from decode to respond. An
// inquiry scans the degrees of the n vertices in use (no scan if n is zero) and then walks
// the vertices reached from vertex 0: the edge matrix has one read port, so the degree scan
// reads one row a cycle and the reachability walk spends a pick state and an accumulate
// state on each reached vertex. busy drops in the cycle the result is shown. Configuration
// writes are always taken (csr_ready stays high) and must only come while the block is idle.
// depends on amgc_pkg, amgc_ctrl and amgc_dpath

module adjacency_matrix_graph_checker
   import amgc_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_item,
   output logic                  rsp_valid,
   output rsp_type               rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   amgc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   amgc_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### sv/amgc_ctrl.sv
// amgc_ctrl: sequencer for edge writes and inquiries of the graph checker
// depends on amgc_pkg; drives amgc_dpath through cmd_type and reads status_type

module amgc_ctrl
   import amgc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   logic is_edge;

   assign is_edge = (status.action == ACT_CONNECT) || (status.action == ACT_DISCONNECT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if (is_edge && status.ok) begin
               state_in = ST_EW_WR_SRC;
            end else if (status.action == ACT_INQUIRE) begin
               state_in = status.n_zero ? ST_WALK_PICK : ST_SCAN;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_EW_WR_SRC: begin
            state_in = status.undirected ? ST_EW_RD_DST : ST_RESPOND;
         end
         ST_EW_RD_DST: begin
            state_in = ST_EW_WR_DST;
         end
         ST_EW_WR_DST: begin
            state_in = ST_RESPOND;
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_WALK_PICK;
            end
         end
         ST_WALK_PICK: begin
            state_in = status.pending_any ? ST_WALK_ACC : ST_RESPOND;
         end
         ST_WALK_ACC: begin
            state_in = ST_WALK_PICK;
         end
         ST_RESPOND: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.addr_sel = ADDR_SRC;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_DECODE: begin
            cmd.addr_sel = ADDR_SRC;
         end
         ST_EW_WR_SRC: begin
            cmd.wr_src = 1'b1;
         end
         ST_EW_RD_DST: begin
            cmd.addr_sel = ADDR_DST;
         end
         ST_EW_WR_DST: begin
            cmd.wr_dst = 1'b1;
         end
         ST_SCAN: begin
            cmd.addr_sel   = ADDR_SCAN;
            cmd.scan_issue = 1'b1;
         end
         ST_WALK_PICK: begin
            cmd.addr_sel  = ADDR_PICK;
            cmd.walk_pick = status.pending_any;
         end
         ST_WALK_ACC: begin
            cmd.walk_acc = 1'b1;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### sv/amgc_dpath.sv
// amgc_dpath: edge matrix memory, degree counters, reachability walk and result register
// depends on amgc_pkg; sequenced by amgc_ctrl

module amgc_dpath
   import amgc_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_item,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_valid,
   output rsp_type               rsp_item
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CW    = $clog2(MAX_VERTICES + 1);

   // configuration
   logic [VERTEX_W-1:0] vertex_count_ff;
   logic                undirected_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
         undirected_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_data[VERTEX_W-1:0];
            CSR_UNDIRECTED:   undirected_ff   <= csr_data[0];
            default:          vertex_count_ff <= vertex_count_ff;
         endcase
      end
   end

   // vertices in use, a count above the matrix size means none
   logic [VERTEX_W-1:0]     n_eff;
   logic [MAX_VERTICES-1:0] mask;

   assign n_eff = (int'(vertex_count_ff) > MAX_VERTICES) ? '0 : vertex_count_ff;

   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         mask[j] = (j < int'(n_eff));
      end
   end

   // latched request
   req_type          req_ff;
   logic             ok;
   logic             src_in;
   logic [IDX_W-1:0] src_idx;
   logic [IDX_W-1:0] dst_idx;

   assign src_in  = (req_ff.source < n_eff);
   assign ok      = src_in && (req_ff.dest < n_eff);
   assign src_idx = IDX_W'(req_ff.source);
   assign dst_idx = IDX_W'(req_ff.dest);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
   end

   // edge matrix: one row per entry, a row never written reads as cleared
   logic [MAX_VERTICES-1:0] rows_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [MAX_VERTICES-1:0] rd_data_ff;
   logic                    rd_valid_ff;
   logic [MAX_VERTICES-1:0] row_eff;
   logic [MAX_VERTICES-1:0] row_m;
   logic [IDX_W-1:0]        raddr;
   logic [IDX_W-1:0]        waddr;
   logic [MAX_VERTICES-1:0] wdata;
   logic                    we;
   logic                    set_bit;

   logic [IDX_W-1:0] scan_cnt_ff;
   logic [IDX_W-1:0] pick;

   assign row_eff = rd_valid_ff ? rd_data_ff : '0;
   assign row_m   = row_eff & mask;
   assign set_bit = (req_ff.action == ACT_CONNECT);
   assign we      = cmd.wr_src || cmd.wr_dst;
   assign waddr   = cmd.wr_src ? src_idx : dst_idx;

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_SRC:  raddr = src_idx;
         ADDR_DST:  raddr = dst_idx;
         ADDR_SCAN: raddr = scan_cnt_ff;
         ADDR_PICK: raddr = pick;
         default:   raddr = src_idx;
      endcase
   end

   always_comb begin
      wdata = row_eff;
      if (cmd.wr_src) begin
         wdata[dst_idx] = set_bit;
      end else begin
         wdata[src_idx] = set_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         rows_mem[waddr] <= wdata;
      end
      rd_data_ff  <= rows_mem[raddr];
      rd_valid_ff <= row_valid_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (we) begin
         row_valid_ff[waddr] <= 1'b1;
      end
   end

   // degree scan, reads issued one a cycle and counted in the cycle after
   logic                 scan_vld_d_ff;
   logic [IDX_W-1:0]     scan_idx_d_ff;
   logic [CW-1:0]        row_ones;
   logic [CW-1:0]        rcnt_ff [MAX_VERTICES];
   logic [CW-1:0]        ccnt_ff [MAX_VERTICES];
   logic [CW-1:0]        row_src_ff;
   logic [CW-1:0]        col_src_ff;
   logic                 edge_ff;

   always_comb begin
      row_ones = '0;
      for (int j = 0; j < MAX_VERTICES; j++) begin
         row_ones = row_ones + CW'(row_m[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_vld_d_ff <= 1'b0;
      end else begin
         scan_vld_d_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         scan_cnt_ff <= '0;
      end else if (cmd.scan_issue) begin
         scan_cnt_ff <= scan_cnt_ff + 1'b1;
      end
      scan_idx_d_ff <= scan_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int j = 0; j < MAX_VERTICES; j++) begin
            ccnt_ff[j] <= '0;
         end
         col_src_ff <= '0;
         row_src_ff <= '0;
      end else if (scan_vld_d_ff) begin
         for (int j = 0; j < MAX_VERTICES; j++) begin
            ccnt_ff[j] <= ccnt_ff[j] + CW'(row_m[j]);
         end
         rcnt_ff[scan_idx_d_ff] <= row_ones;
         col_src_ff <= col_src_ff + CW'(row_m[src_idx]);
         if (scan_idx_d_ff == src_idx) begin
            row_src_ff <= row_ones;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         edge_ff <= 1'b0;
      end else if (cmd.wr_src) begin
         edge_ff <= wdata[dst_idx];
      end else if (scan_vld_d_ff && (scan_idx_d_ff == src_idx)) begin
         edge_ff <= row_eff[dst_idx];
      end
   end

   // reachability: visit each reached vertex once, lowest first
   logic [MAX_VERTICES-1:0] seen_ff;
   logic [MAX_VERTICES-1:0] done_ff;
   logic [MAX_VERTICES-1:0] pending;

   assign pending = seen_ff & ~done_ff & mask;

   always_comb begin
      pick = '0;
      for (int j = MAX_VERTICES - 1; j >= 0; j--) begin
         if (pending[j]) begin
            pick = IDX_W'(j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         done_ff <= '0;
      end else if (cmd.load) begin
         seen_ff <= {{(MAX_VERTICES-1){1'b0}}, (n_eff != '0)};
         done_ff <= '0;
      end else begin
         if (cmd.walk_pick) begin
            done_ff[pick] <= 1'b1;
         end
         if (cmd.walk_acc) begin
            seen_ff <= seen_ff | row_m;
         end
      end
   end

   // eulerian check per lane
   logic [MAX_VERTICES-1:0] lane_ok;
   logic                    reach;

   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         lane_ok[j] = !mask[j] ||
                      ((rcnt_ff[j] == ccnt_ff[j]) && (ccnt_ff[j] != '0) && !ccnt_ff[j][0]);
      end
   end

   assign reach = (seen_ff == mask);

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_item_ff;
   rsp_type rsp_in;

   always_comb begin
      rsp_in = '0;
      if (req_ff.action != ACT_UNKNOWN) begin
         rsp_in.accepted     = ok;
         rsp_in.edge_present = ok && edge_ff;
      end
      if (req_ff.action == ACT_INQUIRE) begin
         if (src_in) begin
            rsp_in.row_count    = COUNT_W'(row_src_ff);
            rsp_in.column_count = COUNT_W'(col_src_ff);
         end
         rsp_in.all_reachable = reach;
         rsp_in.eulerian      = reach && (&lane_ok);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_item_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign status.action      = req_ff.action;
   assign status.ok          = ok;
   assign status.undirected  = undirected_ff;
   assign status.n_zero      = (n_eff == '0);
   assign status.scan_last   = ((int'(scan_cnt_ff) + 1) == int'(n_eff));
   assign status.pending_any = |pending;

endmodule
